// ===== rtl/core/hbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_pkg: shared types and constants for the handheld bus decoder
// Transaction payload structs, event kinds, route codes, decode targets and
// the fixed address map of the console.
// ----------------------------------------------------------------------------
package hbd_pkg;

    // Event kinds
    localparam logic [2:0] KIND_READ      = 3'd0;
    localparam logic [2:0] KIND_WRITE     = 3'd1;
    localparam logic [2:0] KIND_IRQ_CHECK = 3'd2;
    localparam logic [2:0] KIND_IME_SET   = 3'd3;
    localparam logic [2:0] KIND_IME_CLEAR = 3'd4;

    // Route codes
    localparam logic [1:0] ROUTE_INTERNAL = 2'd0;
    localparam logic [1:0] ROUTE_CART     = 2'd1;
    localparam logic [1:0] ROUTE_VIDEO    = 2'd2;
    localparam logic [1:0] ROUTE_NONE     = 2'd3;

    // Decode targets
    localparam logic [2:0] TGT_OUT  = 3'd0;
    localparam logic [2:0] TGT_WRAM = 3'd1;
    localparam logic [2:0] TGT_HRAM = 3'd2;
    localparam logic [2:0] TGT_JOYP = 3'd3;
    localparam logic [2:0] TGT_IF   = 3'd4;
    localparam logic [2:0] TGT_IE   = 3'd5;

    // Address map
    localparam logic [15:0] CART_LAST      = 16'h7FFF;
    localparam logic [15:0] VRAM_LAST      = 16'h9FFF;
    localparam logic [15:0] OAM_FIRST      = 16'hFE00;
    localparam logic [15:0] OAM_LAST       = 16'hFE9F;
    localparam logic [15:0] LCD_FIRST      = 16'hFF40;
    localparam logic [15:0] LCD_LAST       = 16'hFF4B;
    localparam logic [15:0] WRAM_BASE      = 16'hC000;
    localparam logic [16:0] WRAM_WIN_MAX   = 17'h02000;
    localparam logic [15:0] JOYP_ADDR      = 16'hFF00;
    localparam logic [15:0] IF_ADDR        = 16'hFF0F;
    localparam logic [15:0] IE_ADDR        = 16'hFFFF;
    localparam logic [15:0] HRAM_BASE      = 16'hFF80;

    // Joypad select bits and interrupt constants
    localparam int         JOYP_SEL_ACTION = 5;
    localparam int         JOYP_SEL_DIR    = 4;
    localparam logic [3:0] JOYP_NIBBLE     = 4'hF;
    localparam int         IRQ_LINES       = 5;
    localparam logic [6:0] VEC_BASE        = 7'h40;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [3:0]  action_keys;
        logic [3:0]  direction_keys;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] route;
        logic       interrupt_taken;
        logic [6:0] vector;
    } rsp_t;

    typedef struct packed {
        logic [1:0] route;
        logic [2:0] tgt;
    } decode_t;

endpackage

// ===== rtl/core/hbd_addr_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbd_addr_decode: CPU address decoder
// Maps a 16-bit byte address onto an internal target or an outward route.
// ----------------------------------------------------------------------------
module hbd_addr_decode #(
    parameter int WORK_RAM_BYTES = 8192,
    parameter int HIGH_RAM_BYTES = 127
) (
    input  logic [15:0]     address,
    output hbd_pkg::decode_t dec
);

    localparam logic [16:0] WRAM_SIZE = 17'(WORK_RAM_BYTES);
    localparam logic [16:0] WRAM_WIN  =
        (WRAM_SIZE < hbd_pkg::WRAM_WIN_MAX) ? WRAM_SIZE : hbd_pkg::WRAM_WIN_MAX;
    localparam logic [16:0] HRAM_SIZE = 17'(HIGH_RAM_BYTES);

    logic [15:0] wram_off;
    logic [15:0] hram_off;
    logic        is_video;

    assign wram_off = address - hbd_pkg::WRAM_BASE;
    assign hram_off = address - hbd_pkg::HRAM_BASE;
    assign is_video = (address <= hbd_pkg::VRAM_LAST)
                   || (address >= hbd_pkg::OAM_FIRST && address <= hbd_pkg::OAM_LAST)
                   || (address >= hbd_pkg::LCD_FIRST && address <= hbd_pkg::LCD_LAST);

    // Walk the map in priority order
    always_comb
    begin
        dec.route = hbd_pkg::ROUTE_INTERNAL;
        dec.tgt   = hbd_pkg::TGT_OUT;
        if (address <= hbd_pkg::CART_LAST)
        begin
            dec.route = hbd_pkg::ROUTE_CART;
        end
        else if (is_video)
        begin
            dec.route = hbd_pkg::ROUTE_VIDEO;
        end
        else if (address >= hbd_pkg::WRAM_BASE && {1'b0, wram_off} < WRAM_WIN)
        begin
            dec.tgt = hbd_pkg::TGT_WRAM;
        end
        else if (address == hbd_pkg::JOYP_ADDR)
        begin
            dec.tgt = hbd_pkg::TGT_JOYP;
        end
        else if (address == hbd_pkg::IF_ADDR)
        begin
            dec.tgt = hbd_pkg::TGT_IF;
        end
        else if (address == hbd_pkg::IE_ADDR)
        begin
            dec.tgt = hbd_pkg::TGT_IE;
        end
        else if (address >= hbd_pkg::HRAM_BASE && {1'b0, hram_off} < HRAM_SIZE)
        begin
            dec.tgt = hbd_pkg::TGT_HRAM;
        end
        else
        begin
            dec.route = hbd_pkg::ROUTE_NONE;
        end
    end

endmodule

// ===== rtl/core/handheld_bus_decode_interrupt_ctrl_unit.sv =====
`timescale 1ns / 1ps
// Takes one CPU transaction per clock while req_ready is high. The first stage
// decodes the address, updates registers and issues the work RAM or high RAM
// access (each a single-port synchronous RAM with a registered read), the
// second forms the response and places it in the output register. Sustained
// rate is one transaction per cycle while responses are taken, set by the one
// access each RAM takes per transaction; writes land at the accepting edge, so
// a read that follows always sees them. While a response waits in the output
// register one more transaction is still accepted. The RAMs are not cleared:
// their contents are undefined until written.
// ----------------------------------------------------------------------------
// handheld_bus_decode_interrupt_ctrl_unit: bus decoder and interrupt control
// Decodes CPU byte accesses, holds work RAM, high RAM, joypad, interrupt
// flag and enable registers and the master enable, and dispatches interrupts.
// ----------------------------------------------------------------------------
module handheld_bus_decode_interrupt_ctrl_unit #(
    parameter int WORK_RAM_BYTES = 8192,
    parameter int HIGH_RAM_BYTES = 127
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  hbd_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output hbd_pkg::rsp_t   rsp
);

    localparam int WA = $clog2(WORK_RAM_BYTES);
    localparam int HA = $clog2(HIGH_RAM_BYTES);

    // Response data source
    localparam logic [1:0] SRC_LOGIC = 2'd0;
    localparam logic [1:0] SRC_WRAM  = 2'd1;
    localparam logic [1:0] SRC_HRAM  = 2'd2;

    logic [7:0] wram_mem [WORK_RAM_BYTES];
    logic [7:0] hram_mem [HIGH_RAM_BYTES];
    logic [7:0] wram_rd_reg;
    logic [7:0] hram_rd_reg;

    logic [7:0] joyp_reg,  joyp_next;
    logic [7:0] iflag_reg, iflag_next;
    logic [7:0] ienable_reg, ienable_next;
    logic       ime_reg,   ime_next;

    logic          s1_valid_reg, s1_valid_next;
    hbd_pkg::rsp_t s1_reg,       s1_next;
    logic [1:0]    s1_src_reg,   s1_src_next;
    logic          rsp_valid_reg, rsp_valid_next;
    hbd_pkg::rsp_t rsp_reg;

    hbd_pkg::decode_t dec;
    logic             accept;
    logic             s1_move;
    logic             is_read;
    logic             is_write;
    logic [WA-1:0]    wram_idx;
    logic [HA-1:0]    hram_idx;
    logic [7:0]       joyp_rd;
    logic [4:0]       pend;
    logic [2:0]       irq_num;
    logic             irq_fire;
    hbd_pkg::rsp_t    s1_full;

    hbd_addr_decode #(
        .WORK_RAM_BYTES (WORK_RAM_BYTES),
        .HIGH_RAM_BYTES (HIGH_RAM_BYTES)
    ) u_decode (
        .address (req.address),
        .dec     (dec)
    );

    // Handshake: s1 drains into the output register when that slot frees
    assign s1_move   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_move;
    assign accept    = req_valid && req_ready;
    assign is_read   = (req.kind == hbd_pkg::KIND_READ);
    assign is_write  = (req.kind == hbd_pkg::KIND_WRITE);

    assign wram_idx = WA'(req.address - hbd_pkg::WRAM_BASE);
    assign hram_idx = HA'(req.address - hbd_pkg::HRAM_BASE);

    // Joypad read: refresh the low nibble from the selected key group
    always_comb
    begin
        joyp_rd = joyp_reg;
        if (!joyp_reg[hbd_pkg::JOYP_SEL_ACTION])
        begin
            joyp_rd = {joyp_reg[7:4], ~req.action_keys};
        end
        else if (!joyp_reg[hbd_pkg::JOYP_SEL_DIR])
        begin
            joyp_rd = {joyp_reg[7:4], ~req.direction_keys};
        end
    end

    // Pick the lowest pending and enabled line
    assign pend     = iflag_reg[hbd_pkg::IRQ_LINES-1:0] & ienable_reg[hbd_pkg::IRQ_LINES-1:0];
    assign irq_fire = ime_reg && (pend != '0);
    always_comb
    begin
        irq_num = 3'd0;
        for (int i = hbd_pkg::IRQ_LINES - 1; i >= 0; i--)
        begin
            if (pend[i])
            begin
                irq_num = 3'(i);
            end
        end
    end

    // Register updates and first-stage response
    always_comb
    begin
        joyp_next    = joyp_reg;
        iflag_next   = iflag_reg;
        ienable_next = ienable_reg;
        ime_next     = ime_reg;
        s1_next      = '0;
        s1_src_next  = SRC_LOGIC;
        case (req.kind)
            hbd_pkg::KIND_READ,
            hbd_pkg::KIND_WRITE:
            begin
                s1_next.route = dec.route;
                case (dec.tgt)
                    hbd_pkg::TGT_WRAM:
                    begin
                        s1_src_next = is_read ? SRC_WRAM : SRC_LOGIC;
                    end
                    hbd_pkg::TGT_HRAM:
                    begin
                        s1_src_next = is_read ? SRC_HRAM : SRC_LOGIC;
                    end
                    hbd_pkg::TGT_JOYP:
                    begin
                        if (is_read)
                        begin
                            joyp_next         = joyp_rd;
                            s1_next.read_data = joyp_rd;
                        end
                        else
                        begin
                            joyp_next = {req.write_data[7:4], hbd_pkg::JOYP_NIBBLE};
                        end
                    end
                    hbd_pkg::TGT_IF:
                    begin
                        if (is_read)
                        begin
                            s1_next.read_data = iflag_reg;
                        end
                        else
                        begin
                            iflag_next = req.write_data;
                        end
                    end
                    hbd_pkg::TGT_IE:
                    begin
                        if (is_read)
                        begin
                            s1_next.read_data = ienable_reg;
                        end
                        else
                        begin
                            ienable_next = req.write_data;
                        end
                    end
                    default:
                    begin
                        s1_next.read_data = '0;
                    end
                endcase
            end
            hbd_pkg::KIND_IRQ_CHECK:
            begin
                if (irq_fire)
                begin
                    iflag_next[irq_num]     = 1'b0;
                    ime_next                = 1'b0;
                    s1_next.interrupt_taken = 1'b1;
                    s1_next.vector          = hbd_pkg::VEC_BASE + {1'b0, irq_num, 3'b000};
                end
            end
            hbd_pkg::KIND_IME_SET:
            begin
                ime_next = 1'b1;
            end
            hbd_pkg::KIND_IME_CLEAR:
            begin
                ime_next = 1'b0;
            end
            default:
            begin
                ime_next = ime_reg;
            end
        endcase
    end

    // Hold control and register state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joyp_reg    <= '1;
            iflag_reg   <= '0;
            ienable_reg <= '0;
            ime_reg     <= 1'b0;
        end
        else if (accept)
        begin
            joyp_reg    <= joyp_next;
            iflag_reg   <= iflag_next;
            ienable_reg <= ienable_next;
            ime_reg     <= ime_next;
        end
    end

    // Work RAM: one write or one registered read per transaction
    always_ff @(posedge clk)
    begin
        if (accept && dec.tgt == hbd_pkg::TGT_WRAM)
        begin
            if (is_write)
            begin
                wram_mem[wram_idx] <= req.write_data;
            end
            else if (is_read)
            begin
                wram_rd_reg <= wram_mem[wram_idx];
            end
        end
    end

    // High RAM: one write or one registered read per transaction
    always_ff @(posedge clk)
    begin
        if (accept && dec.tgt == hbd_pkg::TGT_HRAM)
        begin
            if (is_write)
            begin
                hram_mem[hram_idx] <= req.write_data;
            end
            else if (is_read)
            begin
                hram_rd_reg <= hram_mem[hram_idx];
            end
        end
    end

    // Merge RAM read data into the second-stage response
    always_comb
    begin
        s1_full = s1_reg;
        case (s1_src_reg)
            SRC_WRAM: s1_full.read_data = wram_rd_reg;
            SRC_HRAM: s1_full.read_data = hram_rd_reg;
            default:  s1_full.read_data = s1_reg.read_data;
        endcase
    end

    // Advance the two response stages
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        rsp_valid_next = rsp_valid_reg;
        if (s1_move)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg     <= s1_next;
            s1_src_reg <= s1_src_next;
        end
        if (s1_move)
        begin
            rsp_reg <= s1_full;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Taking an interrupt drops the master enable
    a_ime_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == hbd_pkg::KIND_IRQ_CHECK && irq_fire) |=> !ime_reg)
        else $error("master enable still set after interrupt dispatch");

    // A vector is present exactly when an interrupt was taken
    a_vec_taken: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_reg.interrupt_taken == (s1_reg.vector != '0)))
        else $error("vector and interrupt_taken disagree");

    // Input stalls only when both response stages are occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (s1_valid_reg && rsp_valid_reg))
        else $error("input stalled with a free response stage");

    // Routed or unmapped accesses never return data
    a_route_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.route != hbd_pkg::ROUTE_INTERNAL)
            |-> (rsp_reg.read_data == '0))
        else $error("routed access returned data");

    // RAM data is only selected for internal accesses
    a_src_internal: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_src_reg != SRC_LOGIC)
            |-> (s1_reg.route == hbd_pkg::ROUTE_INTERNAL && !s1_reg.interrupt_taken))
        else $error("RAM source on a non-internal response");

endmodule
